// File: sv/sorted_priority_queue_assert.svh
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// File: sv/spq_pkg.sv
// Package for the sorted priority queue: request, result and control types.
package spq_pkg;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_RESERVED  = 2'd3
    } status_t;

    typedef enum logic {
        MODE_ENQUEUE = 1'b0,
        MODE_DEQUEUE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] new_priority;
        logic [7:0] new_symbol;
    } req_t;

    typedef struct packed {
        logic [7:0] out_priority;
        logic [7:0] out_symbol;
        logic [4:0] entry_count;
        logic       is_empty;
        logic       is_full;
        status_t    status;
    } rsp_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

    localparam int CAP_BITS = 5;

endpackage

// File: sv/sorted_priority_queue.sv
// Sorted priority queue top level: a chain of entry cells with a count and result register.
// Takes one request on every clock (busy stays low) and reports its result in the next cycle
// with a one-cycle done pulse. Each cell compares its own entry with the new priority and
// shifts with its neighbours, so insert and removal cost the same whatever the fill level.
// Entries of equal priority leave in arrival order; cfg_data sets the capacity (0 counts as 1).
module sorted_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  spq_pkg::req_t                      cmd,
    output logic                               done,
    output spq_pkg::rsp_t                      result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spq_pkg::CAP_BITS-1:0]       cfg_data
);
    import spq_pkg::*;
    `include "sorted_priority_queue_assert.svh"

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int PW   = PRIO_BITS;

    logic [CAP_BITS-1:0] cap_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                done_reg;
    rsp_t                result_reg, result_next;

    logic [CMPW-1:0] cap_w, count_w, count_next_w, eff_cap;
    logic            accept, enq_ok, deq_ok;
    cell_ctl_t       ctl;

    logic [PW+7:0]   np_wide;
    logic [PW-1:0]   np;
    logic [PW+7:0]   head_wide;
    logic [CMPW+4:0] count_out_wide;

    logic [PW-1:0] cell_prio [DEPTH];
    logic [7:0]    cell_sym  [DEPTH];
    logic          cell_gt   [DEPTH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign np_wide = {{PW{1'b0}}, cmd.new_priority};
    assign np      = np_wide[PW-1:0];

    assign cap_w   = CMPW'(cap_reg);
    assign count_w = CMPW'(count_reg);
    always_comb
    begin
        if (cap_w == '0)
            eff_cap = CMPW'(1);
        else if (cap_w > CMPW'(DEPTH))
            eff_cap = CMPW'(DEPTH);
        else
            eff_cap = cap_w;
    end

    assign enq_ok  = accept && (cmd.mode == MODE_ENQUEUE) && (count_w < eff_cap);
    assign deq_ok  = accept && (cmd.mode == MODE_DEQUEUE) && (count_reg != '0);
    assign ctl     = {enq_ok, deq_ok};

    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
            count_next = count_reg + CW'(1);
        else if (deq_ok)
            count_next = count_reg - CW'(1);
    end
    assign count_next_w = CMPW'(count_next);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam int L = (i == 0) ? 0 : i - 1;
            localparam int R = (i == DEPTH - 1) ? i : i + 1;
            spq_cell #(
                .PW(PW)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occ        (CW'(i) < count_reg),
                .new_prio   (np),
                .new_sym    (cmd.new_symbol),
                .left_prio  (cell_prio[L]),
                .left_sym   (cell_sym[L]),
                .left_gt    ((i == 0) ? 1'b0 : cell_gt[L]),
                .right_prio (cell_prio[R]),
                .right_sym  (cell_sym[R]),
                .prio       (cell_prio[i]),
                .sym        (cell_sym[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    assign head_wide      = {8'b0, cell_prio[0]};
    assign count_out_wide = {5'b0, count_next_w};

    always_comb
    begin
        result_next              = '0;
        result_next.entry_count  = count_out_wide[4:0];
        result_next.is_empty     = (count_next == '0);
        result_next.is_full      = (count_next_w >= eff_cap);
        result_next.status       = STATUS_OK;
        if (deq_ok)
        begin
            result_next.out_priority = head_wide[7:0];
            result_next.out_symbol   = cell_sym[0];
        end
        else if (accept && (cmd.mode == MODE_ENQUEUE) && !enq_ok)
            result_next.status = STATUS_FULL;
        else if (accept && (cmd.mode == MODE_DEQUEUE) && !deq_ok)
            result_next.status = STATUS_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_BITS'(16);
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SPQ_ASSERT_NEXT(a_done_follows_request, accept, done)
    `SPQ_ASSERT_NOW(a_count_bounded, 1'b1, count_w <= CMPW'(DEPTH))
    `SPQ_ASSERT_NEXT(a_refused_keeps_count, accept && !enq_ok && !deq_ok, $stable(count_reg))
    `SPQ_ASSERT_NOW(a_head_sorted, count_reg >= CW'(2), cell_prio[0] <= cell_prio[1])

endmodule

// File: sv/spq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbours.
module spq_cell #(
    parameter int PW = 8
) (
    input  logic              clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic              occ,
    input  logic [PW-1:0]     new_prio,
    input  logic [7:0]        new_sym,
    input  logic [PW-1:0]     left_prio,
    input  logic [7:0]        left_sym,
    input  logic              left_gt,
    input  logic [PW-1:0]     right_prio,
    input  logic [7:0]        right_sym,
    output logic [PW-1:0]     prio,
    output logic [7:0]        sym,
    output logic              gt
);
    import spq_pkg::*;

    logic [PW-1:0] prio_reg, prio_next;
    logic [7:0]    sym_reg, sym_next;

    // An empty cell or one holding a larger priority lies behind the insert point.
    assign gt = !occ || (prio_reg > new_prio);

    always_comb
    begin
        prio_next = prio_reg;
        sym_next  = sym_reg;
        if (ctl.deq)
        begin
            prio_next = right_prio;
            sym_next  = right_sym;
        end
        else if (ctl.enq && gt)
        begin
            if (left_gt)
            begin
                prio_next = left_prio;
                sym_next  = left_sym;
            end
            else
            begin
                prio_next = new_prio;
                sym_next  = new_sym;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        sym_reg  <= sym_next;
    end

    assign prio = prio_reg;
    assign sym  = sym_reg;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int STALL_LIMIT    = 500;
    localparam int PHASE_REQUESTS = 60;

    typedef struct {
        bit         is_cfg;
        logic [4:0] cap;
        req_t       req;
        bit         pinned;
        rsp_t       want;
    } step_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    req_t                cmd       = '0;
    logic                done;
    rsp_t                result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_data  = '0;

    // Side channel carrying a hand-written expectation alongside the request.
    bit                  pin_valid = 1'b0;
    rsp_t                pin_want  = '0;

    // Predictor state: entries kept in a circular store in ascending priority order.
    logic [7:0] held_prio [DEPTH];
    logic [7:0] held_sym  [DEPTH];
    logic [3:0] head_pos    = '0;
    int         held_total  = 0;
    int         cap_setting = 16;

    rsp_t awaited [$];
    int   mismatches   = 0;
    int   stall_cycles = 0;

    sorted_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report(string msg);
        $display("tb: mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic logic [3:0] slot(int logical);
        return 4'(head_pos + logical);
    endfunction

    // Applies one request to the predictor state and returns the result it should give.
    function automatic rsp_t queue_apply(req_t r);
        rsp_t o;
        int   cap;
        int   pos;
        int   k;
        cap = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
        o = '0;
        if (r.mode == MODE_ENQUEUE)
        begin
            if (held_total >= cap)
            begin
                o.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < held_total && held_prio[slot(pos)] <= r.new_priority)
                    pos++;
                for (k = held_total; k > pos; k--)
                begin
                    held_prio[slot(k)] = held_prio[slot(k - 1)];
                    held_sym[slot(k)]  = held_sym[slot(k - 1)];
                end
                held_prio[slot(pos)] = r.new_priority;
                held_sym[slot(pos)]  = r.new_symbol;
                held_total++;
            end
        end
        else
        begin
            if (held_total == 0)
            begin
                o.status = STATUS_EMPTY;
            end
            else
            begin
                o.out_priority = held_prio[head_pos];
                o.out_symbol   = held_sym[head_pos];
                head_pos       = head_pos + 4'd1;
                held_total--;
            end
        end
        o.entry_count = 5'(held_total);
        o.is_empty    = (held_total == 0);
        o.is_full     = (held_total >= cap);
        return o;
    endfunction

    task automatic compare_result(rsp_t got, rsp_t want);
        if (got.out_priority !== want.out_priority)
            report($sformatf("out_priority %0h, expected %0h", got.out_priority,
                             want.out_priority));
        if (got.out_symbol !== want.out_symbol)
            report($sformatf("out_symbol %0h, expected %0h", got.out_symbol, want.out_symbol));
        if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, expected %0d", got.entry_count,
                             want.entry_count));
        if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
        if (got.is_full !== want.is_full)
            report($sformatf("is_full %b, expected %b", got.is_full, want.is_full));
        if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask

    // Sampling at the rising edge: register writes, accepted requests and results in one place.
    always @(posedge clk)
    begin
        rsp_t predicted;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                cap_setting = cfg_data;
            if (start && !busy)
            begin
                predicted = queue_apply(cmd);
                awaited.push_back(pin_valid ? pin_want : predicted);
            end
            if (done)
            begin
                if (awaited.size() == 0)
                    report("result arrived with nothing awaited");
                else
                    compare_result(result, awaited.pop_front());
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: errors");
        $finish;
    end

    function automatic req_t cmd_of(mode_t m, logic [7:0] p, logic [7:0] s);
        req_t r;
        r.mode         = m;
        r.new_priority = p;
        r.new_symbol   = s;
        return r;
    endfunction

    function automatic rsp_t outcome(logic [7:0] op, logic [7:0] os, logic [4:0] cnt,
                                     logic emp, logic full, status_t st);
        rsp_t o;
        o.out_priority = op;
        o.out_symbol   = os;
        o.entry_count  = cnt;
        o.is_empty     = emp;
        o.is_full      = full;
        o.status       = st;
        return o;
    endfunction

    function automatic step_t plain(req_t r);
        step_t s;
        s.is_cfg = 1'b0;
        s.cap    = '0;
        s.req    = r;
        s.pinned = 1'b0;
        s.want   = '0;
        return s;
    endfunction

    function automatic step_t pinned(req_t r, rsp_t w);
        step_t s;
        s        = plain(r);
        s.pinned = 1'b1;
        s.want   = w;
        return s;
    endfunction

    function automatic step_t cfg_row(logic [4:0] v);
        step_t s;
        s        = plain('0);
        s.is_cfg = 1'b1;
        s.cap    = v;
        return s;
    endfunction

    function automatic req_t random_req(int enq_pct);
        req_t r;
        r.mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
        case ($urandom_range(0, 3))
            0:       r.new_priority = 8'($urandom_range(0, 255));
            1:       r.new_priority = 8'($urandom_range(0, 3));
            2:       r.new_priority = 8'($urandom_range(252, 255));
            default: r.new_priority = 8'($urandom_range(0, 7) * 32);
        endcase
        r.new_symbol = 8'($urandom);
        return r;
    endfunction

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Register writes wait until the queue has answered every request in flight.
    task automatic issue(step_t s);
        if (s.is_cfg)
        begin
            pause(1);
            while (awaited.size() != 0)
                @(posedge clk);
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= s.cap;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
        end
        else
        begin
            start     <= 1'b1;
            cmd       <= s.req;
            pin_valid <= s.pinned;
            pin_want  <= s.want;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    initial
    begin
        step_t plan [$];
        int    caps [11];
        int    phase;
        int    sent;
        int    burst;
        int    bias;
        int    k;
        int    drain;
        bit    quiet;

        caps = '{16, 1, 5, 0, 31, 2, 17, 8, 16, 3, 12};

        // Fill past a lowered capacity, check refusals, ties and the capacity limits.
        plan.push_back(pinned(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00),
                              outcome(8'h00, 8'h00, 5'd0, 1'b1, 1'b0, STATUS_EMPTY)));
        plan.push_back(pinned(cmd_of(MODE_ENQUEUE, 8'hFF, 8'hFF),
                              outcome(8'h00, 8'h00, 5'd1, 1'b0, 1'b0, STATUS_OK)));
        plan.push_back(pinned(cmd_of(MODE_ENQUEUE, 8'h00, 8'h00),
                              outcome(8'h00, 8'h00, 5'd2, 1'b0, 1'b0, STATUS_OK)));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'h00, 8'h11)));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'h80, 8'hA5)));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'hFF, 8'h5A)));
        plan.push_back(cfg_row(5'd3));
        plan.push_back(pinned(cmd_of(MODE_ENQUEUE, 8'h07, 8'h77),
                              outcome(8'h00, 8'h00, 5'd5, 1'b0, 1'b1, STATUS_FULL)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'hFF, 8'hFF)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h55, 8'hAA)));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'hC8, 8'hC8)));
        plan.push_back(pinned(cmd_of(MODE_ENQUEUE, 8'h01, 8'h01),
                              outcome(8'h00, 8'h00, 5'd3, 1'b0, 1'b1, STATUS_FULL)));
        plan.push_back(cfg_row(5'd0));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(pinned(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00),
                              outcome(8'h00, 8'h00, 5'd0, 1'b1, 1'b0, STATUS_EMPTY)));
        plan.push_back(pinned(cmd_of(MODE_ENQUEUE, 8'h09, 8'h09),
                              outcome(8'h00, 8'h00, 5'd1, 1'b0, 1'b1, STATUS_OK)));
        plan.push_back(pinned(cmd_of(MODE_ENQUEUE, 8'h09, 8'hAA),
                              outcome(8'h00, 8'h00, 5'd1, 1'b0, 1'b1, STATUS_FULL)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(cfg_row(5'd31));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'h7F, 8'h80)));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'h80, 8'h7F)));
        plan.push_back(plain(cmd_of(MODE_ENQUEUE, 8'h7F, 8'h01)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));
        plan.push_back(plain(cmd_of(MODE_DEQUEUE, 8'h00, 8'h00)));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue(plan[i]);

        // Each phase changes the capacity without draining first, so it often drops below
        // the count; the bias swings between filling and emptying to reach both limits.
        for (phase = 0; phase < 11; phase++)
        begin
            issue(cfg_row(5'(caps[phase])));
            quiet = (phase % 3 == 2);
            sent  = 0;
            while (sent < PHASE_REQUESTS)
            begin
                burst = $urandom_range(1, 24);
                case ($urandom_range(0, 2))
                    0:       bias = 85;
                    1:       bias = 50;
                    default: bias = 15;
                endcase
                for (k = 0; k < burst && sent < PHASE_REQUESTS; k++)
                begin
                    issue(plain(random_req(bias)));
                    sent++;
                end
                if (!quiet && $urandom_range(0, 1) == 1)
                    pause($urandom_range(1, 8));
            end
        end

        start <= 1'b0;
        drain = 0;
        while (awaited.size() != 0 && drain < 100)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (4) @(posedge clk);
        if (awaited.size() != 0)
            report($sformatf("%0d results never arrived", awaited.size()));
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
